[hw/rtl/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define CHK_NEXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[hw/rtl/pfp_pkg.sv]
package pfp_pkg;
	localparam logic [2:0] FN_PIN   = 3'd0;
	localparam logic [2:0] FN_UNPIN = 3'd1;
	localparam logic [2:0] FN_DIRTY = 3'd2;
	localparam logic [2:0] FN_FORCE = 3'd3;
	localparam logic [2:0] FN_FLUSH = 3'd4;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [2:0]  func;
		logic [23:0] page_num;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  frame_index;
		logic        hit;
		logic        load_needed;
		logic        writeback_needed;
		logic [23:0] writeback_page;
		logic [31:0] read_total;
		logic [31:0] write_total;
		logic        last;
	} out_item_t;

	// per-cell command from the controller
	typedef struct packed {
		logic hit_pin;     // pin increment on selected frame
		logic unpin;
		logic set_dirty;
		logic clr_dirty;
		logic fill;        // load page into selected frame
		logic age_all;     // all unselected valid frames age by one, selected becomes 0
		logic touch;       // newer than selected frame age by one, selected becomes 0
	} cell_cmd_t;
endpackage

[hw/rtl/pfp_cell.sv]
module pfp_cell #(
	parameter int PAGE_BITS = 24,
	parameter int PIN_BITS  = 8,
	parameter int RANK_BITS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfp_pkg::cell_cmd_t   cmd,
	input  logic                 sel,
	input  logic [PAGE_BITS-1:0] page,
	input  logic [RANK_BITS-1:0] sel_rank,
	output logic                 match,
	output logic                 valid,
	output logic                 dirty,
	output logic                 unpinned,
	output logic [RANK_BITS-1:0] rank,
	output logic [PAGE_BITS-1:0] page_out
);
	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q, dirty_q;
	logic [PIN_BITS-1:0]  pin_q;
	logic [RANK_BITS-1:0] rank_q;

	assign match    = valid_q && (page_q == page);
	assign valid    = valid_q;
	assign dirty    = dirty_q;
	assign unpinned = (pin_q == '0);
	assign rank     = rank_q;
	assign page_out = page_q;

	always_ff @(posedge clk) begin
		if (sel && cmd.fill) page_q <= page;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			pin_q   <= '0;
			rank_q  <= '0;
		end else begin
			if (sel) begin
				if (cmd.fill) begin
					valid_q <= 1'b1;
					dirty_q <= 1'b0;
					pin_q   <= PIN_BITS'(1);
				end
				if (cmd.hit_pin && pin_q != '1) pin_q <= pin_q + 1'b1;
				if (cmd.unpin && pin_q != '0) pin_q <= pin_q - 1'b1;
				if (cmd.set_dirty) dirty_q <= 1'b1;
				if (cmd.clr_dirty) dirty_q <= 1'b0;
			end
			if (cmd.age_all) begin
				if (sel) rank_q <= '0;
				else if (valid_q) rank_q <= rank_q + 1'b1;
			end else if (cmd.touch) begin
				if (sel) rank_q <= '0;
				else if (valid_q && rank_q < sel_rank) rank_q <= rank_q + 1'b1;
			end
		end
	end
endmodule

[hw/rtl/page_frame_pool_fifo_lru.sv]
// Channel  | Signals                      | Direction
// in       | in_valid/in_stall/in_item    | to block
// out      | out_valid/out_stall/out_item | from block
// cfg      | cfg_we/cfg_wdata             | to block
// A non-flush item passes through accept, lookup, a victim scan walking
// the cell row, action, and the output transfer.
// Flush scans one frame per cycle and stops for one output transfer per
// written-back frame; an empty flush scans every frame, then sends a last result.
// Reset clears all frames, counters and policy to FIFO.
// A stalled result holds; the next item waits until it is taken.
module page_frame_pool_fifo_lru #(
	parameter int NUM_FRAMES = 16,
	parameter int PAGE_BITS  = 24,
	parameter int PIN_BITS   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  pfp_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output pfp_pkg::out_item_t out_item
);
`include "assert_macros.svh"
	localparam int IB = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CB = $clog2(NUM_FRAMES + 1);
	localparam int RB = IB;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001, S_LOOK = 5'b00010, S_SCAN = 5'b00100,
		S_ACT = 5'b01000, S_OUT = 5'b10000
	} st_t;
	st_t st_q;

	logic                 policy_q;
	logic [2:0]           func_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [CB-1:0]        idx_q;
	logic                 found_q, free_q, vic_q;
	logic [IB-1:0]        hit_i_q, free_i_q, vic_i_q;
	logic [IB-1:0]        tgt_i;
	logic [31:0]          rd_q, wr_q;
	logic [31:0]          rd_sat, wr_sat;
	pfp_pkg::out_item_t   res_q;
	pfp_pkg::out_item_t   res_d;
	logic                 res_ld;
	logic                 flush_more;

	pfp_pkg::cell_cmd_t   cmd;
	logic [NUM_FRAMES-1:0] c_match, c_valid, c_dirty, c_unp, c_sel, c_fl;
	logic [RB-1:0]        c_rank [NUM_FRAMES];
	logic [PAGE_BITS-1:0] c_page [NUM_FRAMES];
	logic [RB-1:0]        sel_rank;
	logic [IB-1:0]        sidx;

	genvar g;
	generate
		for (g = 0; g < NUM_FRAMES; g++) begin : g_cell
			pfp_cell #(.PAGE_BITS(PAGE_BITS), .PIN_BITS(PIN_BITS), .RANK_BITS(RB)) u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd), .sel(c_sel[g]),
				.page(page_q), .sel_rank(sel_rank), .match(c_match[g]),
				.valid(c_valid[g]), .dirty(c_dirty[g]), .unpinned(c_unp[g]),
				.rank(c_rank[g]), .page_out(c_page[g]));
		end
	endgenerate

	assign sidx     = idx_q[IB-1:0];
	assign sel_rank = c_rank[tgt_i];
	assign in_stall = (st_q != S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign out_item = res_q;
	assign c_fl     = c_valid & c_dirty & c_unp;
	assign rd_sat   = (rd_q != '1) ? rd_q + 1'b1 : rd_q;
	assign wr_sat   = (wr_q != '1) ? wr_q + 1'b1 : wr_q;

	logic [23:0] pg24;
	assign pg24 = 24'(c_page[tgt_i]);

	always_comb begin
		cmd = '0;
		c_sel = '0;
		tgt_i = found_q ? hit_i_q : (free_q ? free_i_q : vic_i_q);
		if (st_q == S_SCAN && func_q == pfp_pkg::FN_FLUSH) tgt_i = sidx;
		if (st_q == S_ACT) begin
			c_sel[tgt_i] = 1'b1;
			case (func_q)
				pfp_pkg::FN_PIN: begin
					if (found_q) begin
						cmd.hit_pin = 1'b1;
						cmd.touch = policy_q;
					end else if (free_q) begin
						cmd.fill = 1'b1;
						cmd.age_all = 1'b1;
					end else if (vic_q) begin
						cmd.fill = 1'b1;
						cmd.touch = 1'b1;
					end
				end
				pfp_pkg::FN_UNPIN: cmd.unpin = found_q;
				pfp_pkg::FN_DIRTY: cmd.set_dirty = found_q;
				pfp_pkg::FN_FORCE: cmd.clr_dirty = found_q;
				default: ;
			endcase
			if (!found_q && func_q != pfp_pkg::FN_PIN) c_sel = '0;
			if (func_q == pfp_pkg::FN_PIN && !found_q && !free_q && !vic_q) c_sel = '0;
		end
		if (st_q == S_SCAN && func_q == pfp_pkg::FN_FLUSH && idx_q < CB'(NUM_FRAMES)
		    && c_fl[sidx]) begin
			c_sel[sidx] = 1'b1;
			cmd.clr_dirty = 1'b1;
		end
	end

	always_comb begin
		flush_more = 1'b0;
		for (int i = 0; i < NUM_FRAMES; i++)
			if (IB'(i) > sidx && c_fl[i]) flush_more = 1'b1;
	end

	always_comb begin
		res_d = '0;
		res_d.read_total = rd_q;
		res_d.write_total = wr_q;
		res_ld = 1'b0;
		if (st_q == S_SCAN && func_q == pfp_pkg::FN_FLUSH) begin
			if (idx_q == CB'(NUM_FRAMES)) begin
				res_ld = 1'b1;
				res_d.last = 1'b1;
			end else if (c_fl[sidx]) begin
				res_ld = 1'b1;
				res_d.frame_index = 4'(sidx);
				res_d.writeback_needed = 1'b1;
				res_d.writeback_page = 24'(c_page[sidx]);
				res_d.write_total = wr_sat;
				res_d.last = !flush_more;
			end
		end else if (st_q == S_ACT) begin
			res_ld = 1'b1;
			res_d.last = 1'b1;
			case (func_q)
				pfp_pkg::FN_PIN: begin
					if (found_q) begin
						res_d.frame_index = 4'(hit_i_q);
						res_d.hit = 1'b1;
					end else if (free_q || vic_q) begin
						res_d.frame_index = 4'(tgt_i);
						res_d.load_needed = 1'b1;
						res_d.read_total = rd_sat;
						if (!free_q && c_dirty[tgt_i]) begin
							res_d.writeback_needed = 1'b1;
							res_d.writeback_page = pg24;
							res_d.write_total = wr_sat;
						end
					end else res_d.status = pfp_pkg::ST_FULL;
				end
				pfp_pkg::FN_UNPIN, pfp_pkg::FN_DIRTY, pfp_pkg::FN_FORCE: begin
					if (!found_q) res_d.status = pfp_pkg::ST_MISSING;
					else begin
						res_d.frame_index = 4'(hit_i_q);
						if (func_q == pfp_pkg::FN_FORCE) begin
							res_d.writeback_needed = 1'b1;
							res_d.writeback_page = pg24;
							res_d.write_total = wr_sat;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE) page_q <= PAGE_BITS'(in_item.page_num);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			policy_q <= 1'b0;
			func_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0; free_q <= 1'b0; vic_q <= 1'b0;
			hit_i_q <= '0; free_i_q <= '0; vic_i_q <= '0;
			rd_q <= '0; wr_q <= '0;
			res_q <= '0;
		end else begin
			if (cfg_we) policy_q <= cfg_wdata;
			if (res_ld) begin
				res_q <= res_d;
				rd_q <= res_d.read_total;
				wr_q <= res_d.write_total;
			end
			case (st_q)
				S_IDLE: if (in_valid) begin
					func_q <= in_item.func;
					idx_q <= '0;
					found_q <= 1'b0; free_q <= 1'b0; vic_q <= 1'b0;
					st_q <= S_LOOK;
				end
				S_LOOK: begin
					for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
						if (c_match[i]) begin
							found_q <= 1'b1;
							hit_i_q <= IB'(i);
						end
						if (!c_valid[i]) begin
							free_q <= 1'b1;
							free_i_q <= IB'(i);
						end
					end
					st_q <= S_SCAN;
				end
				S_SCAN: begin
					if (idx_q == CB'(NUM_FRAMES)) begin
						idx_q <= '0;
						if (func_q == pfp_pkg::FN_FLUSH) st_q <= S_OUT;
						else st_q <= S_ACT;
					end else begin
						if (func_q == pfp_pkg::FN_FLUSH && c_fl[sidx]) st_q <= S_OUT;
						if (func_q == pfp_pkg::FN_PIN && c_unp[sidx]
						    && (!vic_q || c_rank[sidx] > c_rank[vic_i_q])) begin
							vic_q <= 1'b1;
							vic_i_q <= sidx;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				S_ACT: st_q <= S_OUT;
				S_OUT: if (!out_stall) begin
					if (res_q.last) st_q <= S_IDLE;
					else st_q <= S_SCAN;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`CHK_IMPL(a_out_state, clk, arst_n, out_valid, st_q == S_OUT, "valid outside output state")
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && out_stall, $stable(res_q), "result changed while stalled")
	`CHK_IMPL(a_idx, clk, arst_n, st_q == S_SCAN, idx_q <= CB'(NUM_FRAMES), "scan index overrun")
endmodule
